// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// The synthesis build sees empty macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/lrpm_pkg.sv
// ----------------------------------------------------------------------------
// lrpm_pkg
// Shared types, constants and the arctangent table of the reflector block.
// ----------------------------------------------------------------------------
package lrpm_pkg;

    localparam int MAX_SAMPLES_DEF = 2048;
    localparam int CORDIC_ITERS    = 16;

    localparam logic [15:0] THR_RST   = 16'd8000;
    localparam logic [15:0] START_RST = 16'h8000;
    localparam logic [15:0] STEP_RST  = 16'd91;
    localparam logic [31:0] GAP_RST   = 32'd10000;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_START     = 2'd1;
    localparam logic [1:0] REG_STEP      = 2'd2;
    localparam logic [1:0] REG_GAP       = 2'd3;

    localparam logic signed [31:0] CORDIC_X0 = 32'sh26DD3B6A;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ANG, ST_CINIT, ST_CORD, ST_MX, ST_MY, ST_SY,
        ST_GX, ST_GY, ST_GC, ST_ACC, ST_FIN, ST_DIV, ST_DWAIT, ST_OUT
    } t_state;

    function automatic logic signed [31:0] atan_q(input logic [3:0] i);
        logic signed [31:0] v;
        case (i)
            4'd0:    v = 32'sh20000000;
            4'd1:    v = 32'sh12E4051E;
            4'd2:    v = 32'sh09FB385B;
            4'd3:    v = 32'sh051111D4;
            4'd4:    v = 32'sh028B0D43;
            4'd5:    v = 32'sh0145D7E1;
            4'd6:    v = 32'sh00A2F61E;
            4'd7:    v = 32'sh00517C55;
            4'd8:    v = 32'sh0028BE53;
            4'd9:    v = 32'sh00145F2F;
            4'd10:   v = 32'sh000A2F98;
            4'd11:   v = 32'sh000517CC;
            4'd12:   v = 32'sh00028BE6;
            4'd13:   v = 32'sh000145F3;
            4'd14:   v = 32'sh0000A2FA;
            default: v = 32'sh0000517D;
        endcase
        return v;
    endfunction

endpackage

// File: src/lrpm_div.sv
// ----------------------------------------------------------------------------
// lrpm_div
// Radix-2 restoring divider, signed numerator over unsigned count,
// quotient truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrpm_div #(
    parameter int SUM_W = 29,
    parameter int CNT_W = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_num,
    input  logic        [CNT_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_quo
);

    localparam int ITW = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] r_mag;
    logic [CNT_W-1:0] r_rem, r_den;
    logic [ITW-1:0]   r_cnt;
    logic             r_neg, r_busy, r_done;
    logic [CNT_W:0]   trial;
    logic             bit_q;

    always_comb begin
        trial = {r_rem, r_mag[SUM_W-1]};
        bit_q = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ITW'(SUM_W);
                r_neg  <= i_num[SUM_W-1];
                r_mag  <= i_num[SUM_W-1] ? SUM_W'(-i_num) : SUM_W'(i_num);
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= bit_q ? CNT_W'(trial - {1'b0, r_den}) : trial[CNT_W-1:0];
                r_mag  <= {r_mag[SUM_W-2:0], bit_q};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == ITW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_mag) : $signed(r_mag);

endmodule

// File: src/lidar_reflector_pair_midpoint.sv
// ----------------------------------------------------------------------------
// lidar_reflector_pair_midpoint
// Reflector pair finder: CORDIC polar to Cartesian, gap split into two legs,
// midpoint of the leg centroids on the last sample of a scan.
// ----------------------------------------------------------------------------
// Per sample: a dim one goes straight to the final state, a reflective one runs a
// 16-step CORDIC and the shared 18x32 multiplier for angle, x, y and gap squares.
// A last sample with both legs adds four serial divisions (SUM_W-bit quotients), else none;
// SUM_W = 17 + clog2(MAX_SAMPLES + 1): 29 at the default size.
// The result sits in an output register; the next sample is taken meanwhile.
// Synchronous active-low reset restores register defaults and clears the scan.
`include "assert_macros.svh"
module lidar_reflector_pair_midpoint #(
    parameter int MAX_SAMPLES = lrpm_pkg::MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] range_mm, [31:16] intensity
    input  logic        i_s_tlast,   // last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [16:0] target_x_mm, [33:17] target_y_mm, pad
    output logic [0:0]  o_m_tuser,   // [0] found
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = 17 + CNT_W;

    lrpm_pkg::t_state r_state, n_state;

    logic [15:0] r_thr, r_start, r_step;
    logic [31:0] r_gap;

    logic [15:0] r_range;
    logic        r_last, r_hit;

    logic [CNT_W-1:0]       r_idx, r_cnt1, r_cnt2;
    logic signed [SUM_W-1:0] r_sum1x, r_sum1y, r_sum2x, r_sum2y;
    logic signed [17:0]     r_prevx, r_prevy, r_px, r_py;
    logic                   r_second;

    logic signed [31:0] r_x, r_y, r_z;
    logic [1:0]         r_quad;
    logic [3:0]         r_iter;

    logic signed [49:0] r_prod;
    logic [35:0]        r_d2;

    logic [1:0]         r_dsel;
    logic signed [17:0] r_c1x, r_c1y, r_c2x, r_c2y;
    logic               r_found;

    logic               r_out_valid;
    logic signed [16:0] r_tx, r_ty;
    logic               r_out_found;

    // control outputs
    logic               rd_ok, div_start, mul_en;
    logic signed [17:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [49:0] mul_p;

    logic               div_done;
    logic signed [SUM_W-1:0] div_quo, div_num;
    logic [CNT_W-1:0]   div_den;

    logic signed [31:0] xs, ys, cosv, sinv;
    logic [15:0]        ang, uang;
    logic signed [31:0] z0;
    logic signed [17:0] dx, dy;
    logic signed [17:0] mid_sx, mid_sy;

    function automatic logic signed [17:0] scale_mm(input logic signed [49:0] p);
        logic signed [49:0] v;
        v = (p + 50'sd536870912) >>> 30;
        if (v > 50'sd65535)       return 18'sd65535;
        else if (v < -50'sd65535) return -18'sd65535;
        else                      return v[17:0];
    endfunction

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrpm_pkg::ST_IDLE:  if (i_s_tvalid) begin
                n_state = (r_idx < CNT_W'(MAX_SAMPLES)) && (i_s_tdata[31:16] >= r_thr)
                          ? lrpm_pkg::ST_ANG : lrpm_pkg::ST_FIN;
            end
            lrpm_pkg::ST_ANG:   n_state = lrpm_pkg::ST_CINIT;
            lrpm_pkg::ST_CINIT: n_state = lrpm_pkg::ST_CORD;
            lrpm_pkg::ST_CORD:  if (r_iter == 4'(lrpm_pkg::CORDIC_ITERS - 1)) begin
                n_state = lrpm_pkg::ST_MX;
            end
            lrpm_pkg::ST_MX:    n_state = lrpm_pkg::ST_MY;
            lrpm_pkg::ST_MY:    n_state = lrpm_pkg::ST_SY;
            lrpm_pkg::ST_SY:    n_state = (r_cnt1 == '0 || r_second)
                                          ? lrpm_pkg::ST_ACC : lrpm_pkg::ST_GX;
            lrpm_pkg::ST_GX:    n_state = lrpm_pkg::ST_GY;
            lrpm_pkg::ST_GY:    n_state = lrpm_pkg::ST_GC;
            lrpm_pkg::ST_GC:    n_state = lrpm_pkg::ST_ACC;
            lrpm_pkg::ST_ACC:   n_state = lrpm_pkg::ST_FIN;
            lrpm_pkg::ST_FIN: begin
                if (!r_last)                         n_state = lrpm_pkg::ST_IDLE;
                else if (r_cnt1 != '0 && r_cnt2 != '0) n_state = lrpm_pkg::ST_DIV;
                else                                 n_state = lrpm_pkg::ST_OUT;
            end
            lrpm_pkg::ST_DIV:   n_state = lrpm_pkg::ST_DWAIT;
            lrpm_pkg::ST_DWAIT: if (div_done) begin
                n_state = (r_dsel == 2'd3) ? lrpm_pkg::ST_OUT : lrpm_pkg::ST_DIV;
            end
            lrpm_pkg::ST_OUT:   if (!r_out_valid || i_m_tready) begin
                n_state = lrpm_pkg::ST_IDLE;
            end
            default:            n_state = lrpm_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        rd_ok     = 1'b0;
        div_start = 1'b0;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (r_state)
            lrpm_pkg::ST_IDLE: rd_ok = 1'b1;
            lrpm_pkg::ST_ANG: begin
                mul_en = 1'b1;
                mul_a  = $signed(18'(r_idx));
                mul_b  = $signed({16'd0, r_step});
            end
            lrpm_pkg::ST_MX: begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, r_range});
                mul_b  = cosv;
            end
            lrpm_pkg::ST_MY: begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, r_range});
                mul_b  = sinv;
            end
            lrpm_pkg::ST_GX: begin
                mul_en = 1'b1;
                mul_a  = dx;
                mul_b  = 32'(dx);
            end
            lrpm_pkg::ST_GY: begin
                mul_en = 1'b1;
                mul_a  = dy;
                mul_b  = 32'(dy);
            end
            lrpm_pkg::ST_DIV: div_start = 1'b1;
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------- datapath helpers ----------------
    always_comb begin
        xs   = r_x >>> r_iter;
        ys   = r_y >>> r_iter;
        ang  = r_prod[15:0] + r_start;
        uang = ang + 16'd8192;
        z0   = ($signed({18'd0, uang[13:0]}) - 32'sd8192) <<< 16;
        dx   = r_px - r_prevx;
        dy   = r_py - r_prevy;
        case (r_quad)
            2'd0:    begin cosv = r_x;  sinv = r_y;  end
            2'd1:    begin cosv = -r_y; sinv = r_x;  end
            2'd2:    begin cosv = -r_x; sinv = -r_y; end
            default: begin cosv = r_y;  sinv = -r_x; end
        endcase
        case (r_dsel)
            2'd0:    begin div_num = r_sum1x; div_den = r_cnt1; end
            2'd1:    begin div_num = r_sum1y; div_den = r_cnt1; end
            2'd2:    begin div_num = r_sum2x; div_den = r_cnt2; end
            default: begin div_num = r_sum2y; div_den = r_cnt2; end
        endcase
        mid_sx = r_c1x + r_c2x;
        mid_sy = r_c1y + r_c2y;
    end

    lrpm_div #(
        .SUM_W(SUM_W),
        .CNT_W(CNT_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrpm_pkg::ST_IDLE;
            r_thr       <= lrpm_pkg::THR_RST;
            r_start     <= lrpm_pkg::START_RST;
            r_step      <= lrpm_pkg::STEP_RST;
            r_gap       <= lrpm_pkg::GAP_RST;
            r_idx       <= '0;
            r_cnt1      <= '0;
            r_cnt2      <= '0;
            r_sum1x     <= '0;
            r_sum1y     <= '0;
            r_sum2x     <= '0;
            r_sum2y     <= '0;
            r_prevx     <= '0;
            r_prevy     <= '0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
            r_dsel      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lrpm_pkg::REG_THRESHOLD: r_thr   <= i_cfg_data[15:0];
                    lrpm_pkg::REG_START:     r_start <= i_cfg_data[15:0];
                    lrpm_pkg::REG_STEP:      r_step  <= i_cfg_data[15:0];
                    lrpm_pkg::REG_GAP:       r_gap   <= i_cfg_data;
                    default: ;
                endcase
            end
            // the output state reloads the register itself
            if (o_m_tvalid && i_m_tready && r_state != lrpm_pkg::ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (mul_en) r_prod <= mul_p;

            case (r_state)
                lrpm_pkg::ST_IDLE: if (i_s_tvalid) begin
                    r_range <= i_s_tdata[15:0];
                    r_last  <= i_s_tlast;
                    r_hit   <= (r_idx < CNT_W'(MAX_SAMPLES));
                end
                lrpm_pkg::ST_CINIT: begin
                    r_quad <= uang[15:14];
                    r_z    <= z0;
                    r_x    <= lrpm_pkg::CORDIC_X0;
                    r_y    <= '0;
                    r_iter <= '0;
                end
                lrpm_pkg::ST_CORD: begin
                    if (!r_z[31]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - lrpm_pkg::atan_q(r_iter);
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + lrpm_pkg::atan_q(r_iter);
                    end
                    r_iter <= r_iter + 1'b1;
                end
                lrpm_pkg::ST_MY: r_px <= scale_mm(r_prod);
                lrpm_pkg::ST_SY: r_py <= scale_mm(r_prod);
                lrpm_pkg::ST_GY: r_d2 <= r_prod[35:0];
                lrpm_pkg::ST_GC: begin
                    if (r_d2 + r_prod[35:0] > {4'd0, r_gap}) r_second <= 1'b1;
                end
                lrpm_pkg::ST_ACC: begin
                    if (r_second) begin
                        r_sum2x <= r_sum2x + SUM_W'(r_px);
                        r_sum2y <= r_sum2y + SUM_W'(r_py);
                        r_cnt2  <= r_cnt2 + 1'b1;
                    end else begin
                        r_sum1x <= r_sum1x + SUM_W'(r_px);
                        r_sum1y <= r_sum1y + SUM_W'(r_py);
                        r_cnt1  <= r_cnt1 + 1'b1;
                    end
                    r_prevx <= r_px;
                    r_prevy <= r_py;
                end
                lrpm_pkg::ST_FIN: begin
                    if (r_hit) r_idx <= r_idx + 1'b1;
                    r_found <= (r_cnt1 != '0) && (r_cnt2 != '0);
                    r_dsel  <= '0;
                end
                lrpm_pkg::ST_DWAIT: if (div_done) begin
                    case (r_dsel)
                        2'd0:    r_c1x <= div_quo[17:0];
                        2'd1:    r_c1y <= div_quo[17:0];
                        2'd2:    r_c2x <= div_quo[17:0];
                        default: r_c2y <= div_quo[17:0];
                    endcase
                    r_dsel <= r_dsel + 1'b1;
                end
                lrpm_pkg::ST_OUT: if (!r_out_valid || i_m_tready) begin
                    r_out_valid <= 1'b1;
                    r_out_found <= r_found;
                    // round toward zero on the halving
                    r_tx <= r_found ? 17'((mid_sx + 18'(mid_sx[17])) >>> 1) : '0;
                    r_ty <= r_found ? 17'((mid_sy + 18'(mid_sy[17])) >>> 1) : '0;
                    r_idx    <= '0;
                    r_cnt1   <= '0;
                    r_cnt2   <= '0;
                    r_sum1x  <= '0;
                    r_sum1y  <= '0;
                    r_sum2x  <= '0;
                    r_sum2y  <= '0;
                    r_prevx  <= '0;
                    r_prevy  <= '0;
                    r_second <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_s_tready  = rd_ok;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {6'd0, r_ty, r_tx};
    assign o_m_tuser   = r_out_found;

    `ASSERT_IMPLIES(a_leg2_needs_leg1, i_clk, i_rst_n, r_cnt1 == '0, r_cnt2 == '0)
    `ASSERT_IMPLIES(a_leg2_needs_split, i_clk, i_rst_n, !r_second, r_cnt2 == '0)
    `ASSERT_IMPLIES(a_empty_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0], o_m_tdata == '0)
    `ASSERT_ALWAYS(a_idx_bound, i_clk, i_rst_n, r_idx <= CNT_W'(MAX_SAMPLES))

endmodule
